@@ src/hrpa_pkg.sv @@
// Shared types, constants and helpers of the hex record page assembler.
package hrpa_pkg;

    localparam int PAGE_BYTES_DEF      = 128;
    localparam int ITEM_QUEUE_DEPTH    = 2;
    localparam int RESULT_QUEUE_DEPTH  = 4;

    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] REC_DATA    = 8'h00;
    localparam logic [7:0] REC_EOF     = 8'h01;
    localparam logic [7:0] PAD_BYTE    = 8'hFF;

    localparam logic [9:0] POS_IDLE     = 10'd0;
    localparam logic [9:0] POS_COUNT_HI = 10'd1;
    localparam logic [9:0] POS_COUNT_LO = 10'd2;
    localparam logic [9:0] POS_TYPE_HI  = 10'd7;
    localparam logic [9:0] POS_TYPE_LO  = 10'd8;
    localparam logic [9:0] POS_DATA     = 10'd9;
    localparam logic [9:0] POS_DATA_LO  = 10'd10;
    localparam logic [9:0] POS_MAX      = 10'd1023;

    typedef enum logic [1:0] {
        MODE_FEED = 2'd0,
        MODE_READ = 2'd1,
        MODE_TAKE = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic       is_colon;
        logic [3:0] nibble;
        logic [6:0] read_index;
    } t_item;

    typedef struct packed {
        logic        page_ready;
        logic [15:0] load_address;
        logic [7:0]  read_data;
        logic [7:0]  record_type;
    } t_result;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h57);
        end
        return v;
    endfunction

endpackage

@@ src/hrpa_front.sv @@
// Front end: decodes each input item and holds it in a short queue for the back end.
module hrpa_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [1:0]        i_mode,
    input  logic [7:0]        i_char_code,
    input  logic [6:0]        i_read_index,
    output logic              o_valid,
    output hrpa_pkg::t_item   o_item,
    input  logic              i_take
);

    localparam int DEPTH = hrpa_pkg::ITEM_QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    hrpa_pkg::t_item r_item [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;
    hrpa_pkg::t_item in_item;
    logic            wr, rd;

    always_comb begin
        in_item.mode       = hrpa_pkg::t_mode'(i_mode);
        in_item.is_colon   = (i_char_code == hrpa_pkg::CHAR_COLON);
        in_item.nibble     = hrpa_pkg::hex_value(i_char_code);
        in_item.read_index = i_read_index;
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_item[r_rd_ptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_take && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr && !rd) begin
            n_count = r_count + 1'b1;
        end else if (rd && !wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_item[r_wr_ptr] <= in_item;
        end
    end

endmodule

@@ src/hrpa_back.sv @@
// Back end: record parser state, page memory, end-record padding and result staging.
module hrpa_back #(
    parameter int PAGE_BYTES = hrpa_pkg::PAGE_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  hrpa_pkg::t_item     i_item,
    output logic                o_take,
    input  logic [$clog2(hrpa_pkg::RESULT_QUEUE_DEPTH+1)-1:0] i_res_count,
    output logic                o_res_valid,
    output hrpa_pkg::t_result   o_res
);

    localparam int AW  = $clog2(PAGE_BYTES);
    localparam int FW  = $clog2(PAGE_BYTES + 1);
    localparam int RCW = $clog2(hrpa_pkg::RESULT_QUEUE_DEPTH + 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(PAGE_BYTES);
    localparam logic [15:0]   ADDR_STEP = 16'(PAGE_BYTES / 2);

    typedef enum logic [1:0] {
        ST_RUN = 2'b01,
        ST_PAD = 2'b10
    } t_back_state;

    t_back_state  r_state, n_state;
    logic [9:0]   r_pos,   n_pos;
    logic [7:0]   r_bc,    n_bc;
    logic [7:0]   r_type,  n_type;
    logic [3:0]   r_hn,    n_hn;
    logic [FW-1:0] r_fill, n_fill;
    logic         r_first, n_first;
    logic         r_ready, n_ready;
    logic [15:0]  r_addr,  n_addr;

    logic [7:0]   r_mem [PAGE_BYTES];
    logic [7:0]   r_rdata;
    logic         r_s1_valid;
    logic         r_s1_rd_ok;
    hrpa_pkg::t_result r_s1_res;

    logic         wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]   wr_data;
    logic [AW-1:0] rd_addr;
    logic         rd_ok;
    logic         data_end;
    logic [7:0]   byte_val;
    logic [9:0]   last_pos;
    logic [8:0]   idx_ext;
    logic         space;

    assign space    = (RCW'(32'(i_res_count) + 32'(r_s1_valid))
                       < RCW'(hrpa_pkg::RESULT_QUEUE_DEPTH));
    assign o_take   = (r_state == ST_RUN) && i_valid && space;
    assign byte_val = {r_hn, i_item.nibble};
    assign last_pos = 10'd8 + {1'b0, r_bc, 1'b0};
    assign idx_ext  = {2'b00, i_item.read_index};
    assign rd_addr  = idx_ext[AW-1:0];
    assign rd_ok    = (i_item.mode == hrpa_pkg::MODE_READ)
                      && (idx_ext < 9'(PAGE_BYTES));

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_bc     = r_bc;
        n_type   = r_type;
        n_hn     = r_hn;
        n_fill   = r_fill;
        n_first  = r_first;
        n_ready  = r_ready;
        n_addr   = r_addr;
        wr_en    = 1'b0;
        wr_addr  = r_fill[AW-1:0];
        wr_data  = hrpa_pkg::PAD_BYTE;
        data_end = 1'b0;
        unique case (r_state)
            ST_PAD: begin
                wr_en  = 1'b1;
                n_fill = r_fill + 1'b1;
                if (n_fill == FILL_FULL) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (o_take) begin
                    unique case (i_item.mode)
                        hrpa_pkg::MODE_FEED: begin
                            if (i_item.is_colon) begin
                                n_pos = hrpa_pkg::POS_COUNT_HI;
                            end else if (r_pos != hrpa_pkg::POS_IDLE) begin
                                if (r_pos != hrpa_pkg::POS_MAX) begin
                                    n_pos = r_pos + 1'b1;
                                end
                                if (r_pos[0]) begin
                                    if (r_pos == hrpa_pkg::POS_COUNT_HI
                                        || r_pos == hrpa_pkg::POS_TYPE_HI
                                        || r_pos >= hrpa_pkg::POS_DATA) begin
                                        n_hn = i_item.nibble;
                                    end
                                end else if (r_pos == hrpa_pkg::POS_COUNT_LO) begin
                                    n_bc = byte_val;
                                end else if (r_pos == hrpa_pkg::POS_TYPE_LO) begin
                                    n_type = byte_val;
                                    if (byte_val == hrpa_pkg::REC_DATA && r_bc == 8'd0) begin
                                        data_end = 1'b1;
                                    end else if (byte_val == hrpa_pkg::REC_EOF) begin
                                        n_addr  = r_addr + ADDR_STEP;
                                        n_ready = 1'b1;
                                        if (r_fill < FILL_FULL) begin
                                            n_state = ST_PAD;
                                        end
                                    end
                                end else if (r_pos >= hrpa_pkg::POS_DATA_LO
                                             && r_type == hrpa_pkg::REC_DATA
                                             && r_pos <= last_pos) begin
                                    if (r_fill < FILL_FULL) begin
                                        wr_en   = 1'b1;
                                        wr_data = byte_val;
                                        n_fill  = r_fill + 1'b1;
                                    end
                                    if (r_pos == last_pos) begin
                                        data_end = 1'b1;
                                    end
                                end
                            end
                        end
                        hrpa_pkg::MODE_READ: begin
                        end
                        hrpa_pkg::MODE_TAKE: begin
                            n_ready = 1'b0;
                        end
                        hrpa_pkg::MODE_NONE: begin
                        end
                    endcase
                    if (data_end && n_fill == FILL_FULL) begin
                        if (!r_first) begin
                            n_addr = r_addr + ADDR_STEP;
                        end
                        n_first = 1'b0;
                        n_ready = 1'b1;
                        n_fill  = '0;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_RUN;
            r_pos      <= hrpa_pkg::POS_IDLE;
            r_bc       <= '0;
            r_type     <= '0;
            r_hn       <= '0;
            r_fill     <= '0;
            r_first    <= 1'b1;
            r_ready    <= 1'b0;
            r_addr     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_bc       <= n_bc;
            r_type     <= n_type;
            r_hn       <= n_hn;
            r_fill     <= n_fill;
            r_first    <= n_first;
            r_ready    <= n_ready;
            r_addr     <= n_addr;
            r_s1_valid <= o_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_s1_rd_ok               <= rd_ok;
            r_s1_res.page_ready      <= n_ready;
            r_s1_res.load_address    <= n_addr;
            r_s1_res.read_data       <= '0;
            r_s1_res.record_type     <= n_type;
        end
    end

    always_comb begin
        o_res           = r_s1_res;
        o_res.read_data = r_s1_rd_ok ? r_rdata : 8'd0;
    end
    assign o_res_valid = r_s1_valid;

endmodule

@@ src/hrpa_result_queue.sv @@
// Result queue: holds finished results until the consumer transfers them.
module hrpa_result_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  hrpa_pkg::t_result   i_data,
    output logic                o_empty,
    output hrpa_pkg::t_result   o_data,
    input  logic                i_pop,
    output logic [$clog2(hrpa_pkg::RESULT_QUEUE_DEPTH+1)-1:0] o_count
);

    localparam int DEPTH = hrpa_pkg::RESULT_QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    hrpa_pkg::t_result r_slot [DEPTH];
    logic [PW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]     r_count,  n_count;
    logic              wr, rd;

    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign o_count = r_count;
    assign wr      = i_push && (r_count != CW'(DEPTH));
    assign rd      = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr && !rd) begin
            n_count = r_count + 1'b1;
        end else if (rd && !wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ src/hex_record_page_assembler.sv @@
// Top level of the hex record page assembler: front end, back end and result queue.
// The block takes one item per clock while full is low and gives one result per item; a
// result passes through the item queue, the back-end result register and the result
// queue before it shows on the outputs, and can be popped as soon as it shows. The back
// end handles characters, reads and page takes alike. An end record that arrives while
// the page is not full stalls the back end while it fills the rest of the page, because
// the page memory has one write port and the 0xFF padding goes in one byte a cycle; once
// the two-entry item queue fills, full holds the input for the rest of that stall. The
// page memory needs no clearing pass after reset.
module hex_record_page_assembler #(
    parameter int PAGE_BYTES = hrpa_pkg::PAGE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_char_code,
    input  logic [6:0]  i_read_index,
    output logic        empty,
    input  logic        pop,
    output logic        o_page_ready,
    output logic [15:0] o_load_address,
    output logic [7:0]  o_read_data,
    output logic [7:0]  o_record_type
);

    localparam int RCW = $clog2(hrpa_pkg::RESULT_QUEUE_DEPTH + 1);

    logic              q_valid;
    hrpa_pkg::t_item   q_item;
    logic              q_take;
    logic              res_valid;
    hrpa_pkg::t_result res;
    hrpa_pkg::t_result out_res;
    logic [RCW-1:0]    res_count;

    hrpa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_mode       (i_mode),
        .i_char_code  (i_char_code),
        .i_read_index (i_read_index),
        .o_valid      (q_valid),
        .o_item       (q_item),
        .i_take       (q_take)
    );

    hrpa_back #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_take      (q_take),
        .i_res_count (res_count),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    hrpa_result_queue u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_empty (empty),
        .o_data  (out_res),
        .i_pop   (pop),
        .o_count (res_count)
    );

    assign o_page_ready   = out_res.page_ready;
    assign o_load_address = out_res.load_address;
    assign o_read_data    = out_res.read_data;
    assign o_record_type  = out_res.record_type;

    a_take_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_take |-> q_valid)
        else $error("back end took from an empty item queue");

    a_transfer_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> q_valid)
        else $error("transferred item missing from item queue");

    a_result_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (res_count < RCW'(hrpa_pkg::RESULT_QUEUE_DEPTH)))
        else $error("result arrived at a full result queue");

    a_result_follows_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_take |=> res_valid)
        else $error("issued item produced no result");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench of the hex record page assembler with a queue-driven driver and monitor.
module tb_top;

    localparam int PAGE = hrpa_pkg::PAGE_BYTES_DEF;
    localparam logic [9:0] POS_SAT = 10'd1023;

    typedef struct {
        hrpa_pkg::t_mode mode;
        logic [7:0]      ch;
        logic [6:0]      idx;
    } t_page_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_mode;
    logic [7:0]  i_char_code;
    logic [6:0]  i_read_index;
    logic        empty;
    logic        pop;
    logic        o_page_ready;
    logic [15:0] o_load_address;
    logic [7:0]  o_read_data;
    logic [7:0]  o_record_type;

    hex_record_page_assembler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_mode        (i_mode),
        .i_char_code   (i_char_code),
        .i_read_index  (i_read_index),
        .empty         (empty),
        .pop           (pop),
        .o_page_ready  (o_page_ready),
        .o_load_address(o_load_address),
        .o_read_data   (o_read_data),
        .o_record_type (o_record_type)
    );

    t_page_item        pending_chars[$];
    hrpa_pkg::t_result expected_results[$];
    t_page_item        cur_item;
    bit                in_xfer;
    int                n_sent;
    int                n_errors;
    int                send_idle_pct;
    int                recv_stall_pct;

    // predictor state
    logic [9:0]  char_pos;
    logic [7:0]  rec_count;
    logic [7:0]  rec_type;
    logic [3:0]  hi_nib;
    logic [7:0]  page_mem [PAGE];
    int          fill_idx;
    bit          first_pg;
    bit          ready_flag;
    logic [15:0] load_addr;

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= "0" && c <= "9") begin
            d = c - "0";
        end else if (c >= "A" && c <= "F") begin
            d = c - "A" + 8'd10;
        end else if (c >= "a" && c <= "f") begin
            d = c - "a" + 8'd10;
        end
        return d[3:0];
    endfunction

    function automatic void close_data_record();
        if (fill_idx == PAGE) begin
            if (!first_pg) begin
                load_addr = load_addr + 16'(PAGE / 2);
            end
            first_pg = 1'b0;
            ready_flag = 1'b1;
            fill_idx = 0;
        end
    endfunction

    function automatic void close_end_record();
        load_addr = load_addr + 16'(PAGE / 2);
        while (fill_idx < PAGE) begin
            page_mem[fill_idx] = hrpa_pkg::PAD_BYTE;
            fill_idx++;
        end
        ready_flag = 1'b1;
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        logic [9:0] p;
        logic [3:0] v;
        int         last;
        p = char_pos;
        v = digit_value(c);
        last = 8 + 2 * int'(rec_count);
        if (c == hrpa_pkg::CHAR_COLON) begin
            char_pos = 10'd1;
        end else if (p != 10'd0) begin
            if (p < POS_SAT) begin
                char_pos = p + 10'd1;
            end
            if (p[0]) begin
                if (p == 10'd1 || p == 10'd7 || p >= 10'd9) begin
                    hi_nib = v;
                end
            end else if (p == 10'd2) begin
                rec_count = {hi_nib, v};
            end else if (p == 10'd8) begin
                rec_type = {hi_nib, v};
                if (rec_type == hrpa_pkg::REC_DATA && rec_count == 8'd0) begin
                    close_data_record();
                end else if (rec_type == hrpa_pkg::REC_EOF) begin
                    close_end_record();
                end
            end else if (p >= 10'd10 && rec_type == hrpa_pkg::REC_DATA
                         && int'(p) <= last) begin
                if (fill_idx < PAGE) begin
                    page_mem[fill_idx] = {hi_nib, v};
                    fill_idx++;
                end
                if (int'(p) == last) begin
                    close_data_record();
                end
            end
        end
    endfunction

    function automatic hrpa_pkg::t_result predict_page_step(input logic [1:0] mode,
                                                            input logic [7:0] c,
                                                            input logic [6:0] idx);
        hrpa_pkg::t_result r;
        r.read_data = 8'd0;
        if (mode == hrpa_pkg::MODE_FEED) begin
            parse_char(c);
        end else if (mode == hrpa_pkg::MODE_READ) begin
            if (int'(idx) < PAGE) begin
                r.read_data = page_mem[idx];
            end
        end else if (mode == hrpa_pkg::MODE_TAKE) begin
            ready_flag = 1'b0;
        end
        r.page_ready = ready_flag;
        r.load_address = load_addr;
        r.record_type = rec_type;
        return r;
    endfunction

    // stimulus helpers
    function automatic void put_item(input hrpa_pkg::t_mode m, input logic [7:0] c);
        t_page_item it;
        it.mode = m;
        it.ch = c;
        it.idx = 7'($urandom_range(127));
        pending_chars.push_back(it);
    endfunction

    function automatic void put_read(input logic [6:0] idx);
        t_page_item it;
        it.mode = hrpa_pkg::MODE_READ;
        it.ch = 8'($urandom_range(255));
        it.idx = idx;
        pending_chars.push_back(it);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return "0" + 8'(n);
        end
        return ($urandom_range(1) ? "A" : "a") + 8'(n) - 8'd10;
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        logic [7:0] c;
        c = hex_char(b[7:4]);
        if ($urandom_range(59) == 0) begin
            c = 8'($urandom_range(255));
            if (c == hrpa_pkg::CHAR_COLON) begin
                c = "g";
            end
        end
        put_item(hrpa_pkg::MODE_FEED, c);
        put_item(hrpa_pkg::MODE_FEED, hex_char(b[3:0]));
    endfunction

    function automatic void put_record(input logic [7:0] rtype, input int count);
        put_item(hrpa_pkg::MODE_FEED, hrpa_pkg::CHAR_COLON);
        put_byte(8'(count));
        put_byte(8'($urandom_range(255)));
        put_byte(8'($urandom_range(255)));
        put_byte(rtype);
        for (int i = 0; i < count; i++) begin
            put_byte(8'($urandom_range(255)));
        end
        put_byte(8'($urandom_range(255)));
        if ($urandom_range(1)) begin
            put_item(hrpa_pkg::MODE_FEED, 8'h0D);
            put_item(hrpa_pkg::MODE_FEED, 8'h0A);
        end
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            put_item(hrpa_pkg::MODE_FEED, s[i]);
        end
    endfunction

    function automatic void build_stimulus();
        int sel;
        int n;
        // idle mode, text before any colon, end record filling the page, dropped byte
        put_item(hrpa_pkg::MODE_NONE, hrpa_pkg::CHAR_COLON);
        put_item(hrpa_pkg::MODE_FEED, "Z");
        put_text(":00000001FF");
        put_text(":01000000x7");
        put_read(7'd0);
        put_read(7'd127);
        put_item(hrpa_pkg::MODE_TAKE, 8'hFF);
        while (pending_chars.size() < 1640) begin
            sel = $urandom_range(99);
            if (sel < 50) begin
                put_record(hrpa_pkg::REC_DATA,
                           $urandom_range(3) != 0 ? 16 : $urandom_range(40));
            end else if (sel < 51) begin
                put_record(hrpa_pkg::REC_DATA, $urandom_range(255, 100));
            end else if (sel < 55) begin
                put_record(hrpa_pkg::REC_EOF, 0);
            end else if (sel < 59) begin
                put_record(8'($urandom_range(255, 2)), $urandom_range(8));
            end else if (sel < 64) begin
                put_item(hrpa_pkg::MODE_FEED, hrpa_pkg::CHAR_COLON);
                n = $urandom_range(12, 1);
                for (int i = 0; i < n; i++) begin
                    put_item(hrpa_pkg::MODE_FEED, hex_char(4'($urandom_range(15))));
                end
            end else if (sel < 75) begin
                n = $urandom_range(4, 1);
                for (int i = 0; i < n; i++) begin
                    put_read(7'($urandom_range(127)));
                end
            end else if (sel < 81) begin
                put_item(hrpa_pkg::MODE_TAKE, 8'($urandom_range(255)));
            end else if (sel < 84) begin
                put_item(hrpa_pkg::MODE_NONE, 8'($urandom_range(255)));
            end else begin
                n = $urandom_range(4, 1);
                for (int i = 0; i < n; i++) begin
                    put_item(hrpa_pkg::MODE_FEED, 8'($urandom_range(255)));
                end
            end
        end
    endfunction

    function automatic void report_field(input string name, input int unsigned exp_v,
                                         input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t %s expected %0h actual %0h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        hrpa_pkg::t_result want;
        in_xfer = i_rst_n && push && !full;
        if (in_xfer) begin
            expected_results.push_back(predict_page_step(i_mode, i_char_code, i_read_index));
            n_sent++;
        end
        if (i_rst_n && pop && !empty) begin
            if (expected_results.size() == 0) begin
                $display("%0t result with nothing expected", $time);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                report_field("page_ready", want.page_ready, o_page_ready);
                report_field("load_address", want.load_address, o_load_address);
                report_field("read_data", want.read_data, o_read_data);
                report_field("record_type", want.record_type, o_record_type);
            end
        end
        case ((n_sent / 200) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
        endcase
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!push || in_xfer)) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_item = pending_chars.pop_front();
                push <= 1'b1;
                i_mode <= cur_item.mode;
                i_char_code <= cur_item.ch;
                i_read_index <= cur_item.idx;
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_mode = hrpa_pkg::MODE_NONE;
        i_char_code = 8'd0;
        i_read_index = 7'd0;
        in_xfer = 1'b0;
        n_sent = 0;
        n_errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        char_pos = hrpa_pkg::POS_IDLE;
        rec_count = 8'd0;
        rec_type = 8'd0;
        hi_nib = 4'd0;
        fill_idx = 0;
        first_pg = 1'b1;
        ready_flag = 1'b0;
        load_addr = 16'd0;
        build_stimulus();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_chars.size() != 0 || push) begin
            @(posedge i_clk);
        end
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

@@ files.f @@
src/hrpa_pkg.sv
src/hrpa_front.sv
src/hrpa_back.sv
src/hrpa_result_queue.sv
src/hex_record_page_assembler.sv
verif/tb_top.sv
